>>> sv/ffpa_pkg.sv
package ffpa_pkg;

	localparam int MAX_PARTS = 16;
	localparam int ADDR_BITS = 10;
	localparam int IDX_BITS  = $clog2(MAX_PARTS);
	localparam int CNT_BITS  = $clog2(MAX_PARTS + 1);

	localparam logic [ADDR_BITS-1:0] RESERVED_END_RST = ADDR_BITS'(39);
	localparam logic [ADDR_BITS-1:0] MEMORY_END_RST   = ADDR_BITS'(639);

	localparam logic [0:0] REG_RESERVED_END = 1'b0;
	localparam logic [0:0] REG_MEMORY_END   = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_NOOWNER = 3'd2,
		ST_FULL    = 3'd3,
		ST_ZERO    = 3'd4
	} status_t;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [7:0]           proc_id;
		logic [ADDR_BITS-1:0] size;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] block_begin;
		logic [ADDR_BITS-1:0] block_end;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rebuild;   // reload the table from the bounds registers
		logic load_req;  // capture the request, clear the scan index
		logic step;      // advance the scan index
		logic take;      // mark the current entry busy, split if needed
		logic shift_up;  // move one entry up (insert gap)
		logic release_e; // free the current entry
		logic merge_dn;  // merge current entry into its free lower neighbor
		logic merge_up;  // absorb the free upper neighbor
		logic shift_dn;  // move one entry down (close gap)
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;  // scan index beyond the last entry
		logic hit;       // current entry satisfies the request
		logic exact;     // the fit is exact
		logic full;      // table has no room for a split
		logic zero;      // request size is zero
		logic is_free;   // func is free
		logic up_free;   // upper neighbor exists and is free
		logic dn_free;   // lower neighbor exists and is free
		logic up_done;   // upward shift pointer has reached the gap
		logic dn_done;   // downward shift pointer has reached the last entry
	} sts_t;

endpackage

>>> sv/first_fit_partition_allocator_top.sv
// First-fit partition allocator. Raise start with a request while busy is low;
// the single result appears on rsp for one cycle with done high and cannot be
// held off. After a request is taken, busy stays high until the result is
// given; the table scan and the shifts handle one entry per cycle, and done
// marks the last busy cycle. Register writes are taken only while idle with
// start low and rebuild the table at once.
module first_fit_partition_allocator_top import ffpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  req_t                 req,
	output logic                 busy,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [0:0]           cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data
);

	cmd_t                 cmd;
	sts_t                 sts;
	status_t              status;
	logic                 cfg_we;
	logic                 go;
	logic [ADDR_BITS-1:0] cur_begin, cur_end, fit_end;
	logic [ADDR_BITS-1:0] b_q, e_q;

	assign cfg_ready = !busy && !start;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign go        = start && !busy;

	ffpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.cfg_we (cfg_we),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	ffpa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_sel   (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.cur_begin (cur_begin),
		.cur_end   (cur_end),
		.fit_end   (fit_end)
	);

	// Capture the bounds of the chosen entry when it is taken or released.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
			e_q <= '0;
		end else if (cmd.load_req) begin
			b_q <= '0;
			e_q <= '0;
		end else if (cmd.take || cmd.release_e) begin
			b_q <= cur_begin;
			e_q <= (cmd.take && !sts.exact) ? fit_end : cur_end;
		end
	end

	assign rsp.status      = status;
	assign rsp.block_begin = (status == ST_OK) ? b_q : '0;
	assign rsp.block_end   = (status == ST_OK) ? e_q : '0;

`ifndef SYNTHESIS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");
	a_busy_after_go: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status <= ST_ZERO)) else $error("bad status");
`endif

endmodule

>>> sv/ffpa_datapath.sv
module ffpa_datapath import ffpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_sel,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  req_t                 req,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [ADDR_BITS-1:0] cur_begin,
	output logic [ADDR_BITS-1:0] cur_end,
	output logic [ADDR_BITS-1:0] fit_end
);

	logic [ADDR_BITS-1:0] start_q [MAX_PARTS];
	logic [ADDR_BITS-1:0] stop_q  [MAX_PARTS];
	logic [MAX_PARTS-1:0] busy_q;
	logic [7:0]           owner_q [MAX_PARTS];
	logic [CNT_BITS-1:0]  count_q;
	logic [ADDR_BITS-1:0] res_end_q, mem_end_q;
	logic [ADDR_BITS-1:0] res_nx, mem_nx;
	req_t                 req_q;
	logic [CNT_BITS-1:0]  idx_q;   // scan index
	logic [CNT_BITS-1:0]  mv_q;    // shift pointer
	logic [IDX_BITS-1:0]  ix, ix_up, ix_dn, mv, mv_dn, mv_up;
	logic                 in_range;
	logic [ADDR_BITS:0]   len;

	assign ix       = idx_q[IDX_BITS-1:0];
	assign ix_up    = IDX_BITS'(idx_q + 1'b1);
	assign ix_dn    = IDX_BITS'(idx_q - 1'b1);
	assign mv       = mv_q[IDX_BITS-1:0];
	assign mv_dn    = IDX_BITS'(mv_q - 1'b1);
	assign mv_up    = IDX_BITS'(mv_q + 1'b1);
	assign in_range = idx_q < count_q;
	assign len      = {1'b0, stop_q[ix]} - {1'b0, start_q[ix]} + 1'b1;
	assign cur_begin = start_q[ix];
	assign cur_end   = stop_q[ix];
	assign fit_end   = ADDR_BITS'(start_q[ix] + req_q.size - 1'b1);

	// Bounds as they stand after a register transfer in this cycle.
	assign res_nx = (cfg_we && cfg_sel == REG_RESERVED_END) ? cfg_data : res_end_q;
	assign mem_nx = (cfg_we && cfg_sel == REG_MEMORY_END) ? cfg_data : mem_end_q;

	// Status toward the controller.
	always_comb begin
		sts.scan_end = !in_range;
		if (req_q.func == FUNC_ALLOC) begin
			sts.hit = !busy_q[ix] && (stop_q[ix] >= start_q[ix])
				&& (len >= {1'b0, req_q.size});
		end else begin
			sts.hit = busy_q[ix] && (owner_q[ix] == req_q.proc_id);
		end
		sts.exact   = len == {1'b0, req_q.size};
		sts.full    = count_q >= CNT_BITS'(MAX_PARTS);
		sts.zero    = req_q.size == '0;
		sts.is_free = req_q.func == FUNC_FREE;
		sts.up_free = (CNT_BITS'(idx_q + 1'b1) < count_q) && !busy_q[ix_up];
		sts.dn_free = (idx_q != '0) && !busy_q[ix_dn];
		sts.up_done = !(mv_q > CNT_BITS'(idx_q + 1'b1));
		sts.dn_done = !(CNT_BITS'(mv_q + 1'b1) < count_q);
	end

	// Bounds registers, request capture and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_end_q <= RESERVED_END_RST;
			mem_end_q <= MEMORY_END_RST;
			idx_q     <= '0;
			mv_q      <= '0;
		end else begin
			if (cfg_we && cfg_sel == REG_RESERVED_END) res_end_q <= cfg_data;
			if (cfg_we && cfg_sel == REG_MEMORY_END)   mem_end_q <= cfg_data;
			if (cmd.load_req) idx_q <= '0;
			else if (cmd.step) idx_q <= CNT_BITS'(idx_q + 1'b1);
			else if (cmd.merge_dn) idx_q <= CNT_BITS'(idx_q - 1'b1);
			if (cmd.take) mv_q <= count_q;
			else if (cmd.shift_up) mv_q <= CNT_BITS'(mv_q - 1'b1);
			else if (cmd.merge_up) mv_q <= CNT_BITS'(idx_q + 1'b1);
			else if (cmd.merge_dn) mv_q <= idx_q;
			else if (cmd.shift_dn) mv_q <= CNT_BITS'(mv_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
	end

	// Partition table; one entry moves per cycle during inserts and removals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PARTS; k++) begin
				start_q[k] <= (k == 1) ? ADDR_BITS'(RESERVED_END_RST + 1'b1) : '0;
				stop_q[k]  <= (k == 0) ? RESERVED_END_RST
					: ((k == 1) ? MEMORY_END_RST : '0);
				owner_q[k] <= '0;
			end
			busy_q  <= MAX_PARTS'(1);
			count_q <= CNT_BITS'(2);
		end else if (cmd.rebuild) begin
			for (int k = 0; k < MAX_PARTS; k++) begin
				start_q[k] <= (k == 1 && res_nx < mem_nx) ? ADDR_BITS'(res_nx + 1'b1) : '0;
				stop_q[k]  <= (k == 0) ? res_nx
					: ((k == 1 && res_nx < mem_nx) ? mem_nx : '0);
				owner_q[k] <= '0;
			end
			busy_q  <= MAX_PARTS'(1);
			count_q <= (res_nx < mem_nx) ? CNT_BITS'(2) : CNT_BITS'(1);
		end else if (cmd.take) begin
			busy_q[ix]  <= 1'b1;
			owner_q[ix] <= req_q.proc_id;
			if (!sts.exact) begin
				count_q <= CNT_BITS'(count_q + 1'b1);
			end
		end else if (cmd.shift_up) begin
			// Entry mv receives mv-1; the last step writes the remainder and
			// trims the taken entry.
			if (mv_q > CNT_BITS'(idx_q + 1'b1)) begin
				start_q[mv] <= start_q[mv_dn];
				stop_q[mv]  <= stop_q[mv_dn];
				busy_q[mv]  <= busy_q[mv_dn];
				owner_q[mv] <= owner_q[mv_dn];
			end else begin
				start_q[mv] <= ADDR_BITS'(start_q[ix] + req_q.size);
				stop_q[mv]  <= stop_q[ix];
				busy_q[mv]  <= 1'b0;
				owner_q[mv] <= '0;
				stop_q[ix]  <= fit_end;
			end
		end else if (cmd.release_e) begin
			busy_q[ix]  <= 1'b0;
			owner_q[ix] <= '0;
		end else if (cmd.merge_up) begin
			stop_q[ix] <= stop_q[ix_up];
			count_q    <= CNT_BITS'(count_q - 1'b1);
		end else if (cmd.merge_dn) begin
			stop_q[ix_dn] <= stop_q[ix];
			count_q       <= CNT_BITS'(count_q - 1'b1);
		end else if (cmd.shift_dn) begin
			if (CNT_BITS'(mv_q + 1'b1) < CNT_BITS'(count_q + 1'b1)
					&& mv_q < CNT_BITS'(MAX_PARTS - 1)) begin
				start_q[mv] <= start_q[mv_up];
				stop_q[mv]  <= stop_q[mv_up];
				busy_q[mv]  <= busy_q[mv_up];
				owner_q[mv] <= owner_q[mv_up];
			end
		end
	end

endmodule

>>> sv/ffpa_ctrl.sv
module ffpa_ctrl import ffpa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  logic    cfg_we,
	input  sts_t    sts,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output status_t status
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_SCAN    = 9'b000000010,
		S_SHUP    = 9'b000000100,
		S_MUP     = 9'b000001000,
		S_SHDN1   = 9'b000010000,
		S_MDN     = 9'b000100000,
		S_SHDN2   = 9'b001000000,
		S_DONE    = 9'b010000000,
		S_CHECK   = 9'b100000000
	} state_t;

	state_t  state_q, state_d;
	status_t stat_q, stat_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.rebuild = cfg_we;
				if (go) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.is_free && sts.zero) begin
					stat_d  = ST_ZERO;
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					stat_d  = sts.is_free ? ST_NOOWNER : ST_NOSPACE;
					state_d = S_DONE;
				end else if (!sts.hit) begin
					cmd.step = 1'b1;
				end else if (sts.is_free) begin
					cmd.release_e = 1'b1;
					stat_d        = ST_OK;
					state_d       = S_MUP;
				end else if (!sts.exact && sts.full) begin
					stat_d  = ST_FULL;
					state_d = S_DONE;
				end else begin
					cmd.take = 1'b1;
					stat_d   = ST_OK;
					state_d  = sts.exact ? S_DONE : S_SHUP;
				end
			end
			S_SHUP: begin
				cmd.shift_up = 1'b1;
				if (sts.up_done) state_d = S_DONE;
			end
			S_MUP: begin
				if (sts.up_free) begin
					cmd.merge_up = 1'b1;
					state_d      = S_SHDN1;
				end else begin
					state_d = S_MDN;
				end
			end
			S_SHDN1: begin
				cmd.shift_dn = 1'b1;
				if (sts.dn_done) state_d = S_MDN;
			end
			S_MDN: begin
				if (sts.dn_free) begin
					cmd.merge_dn = 1'b1;
					state_d      = S_SHDN2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHDN2: begin
				cmd.shift_dn = 1'b1;
				if (sts.dn_done) state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = state_q == S_DONE;
	assign status = stat_q;

endmodule

>>> tb/ffpa_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels of the allocator.
// It keeps its own partition table, works out the result of each accepted
// request and compares every result with the oldest one still owed.
module ffpa_checker import ffpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  req_t                 req,
	input  logic                 busy,
	input  logic                 done,
	input  rsp_t                 rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [0:0]           cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data,
	output int                   mismatch_count,
	output int                   owed_count,
	output int                   result_count
);

	logic [ADDR_BITS-1:0] sys_last;
	logic [ADDR_BITS-1:0] mem_last;
	logic [ADDR_BITS-1:0] part_first [MAX_PARTS];
	logic [ADDR_BITS-1:0] part_last  [MAX_PARTS];
	logic                 part_taken [MAX_PARTS];
	logic [7:0]           part_owner [MAX_PARTS];
	int                   part_count;
	rsp_t                 owed_q [$];

	// Reload the table from the two bound registers.
	function automatic void reload_table();
		for (int k = 0; k < MAX_PARTS; k++) begin
			part_first[k] = '0;
			part_last[k]  = '0;
			part_taken[k] = 1'b0;
			part_owner[k] = '0;
		end
		part_last[0]  = sys_last;
		part_taken[0] = 1'b1;
		if (sys_last < mem_last) begin
			part_first[1] = sys_last + 1'b1;
			part_last[1]  = mem_last;
			part_count    = 2;
		end else begin
			part_count = 1;
		end
	endfunction

	// Close the gap left by entry k.
	function automatic void drop_entry(int k);
		for (int j = k; j + 1 < part_count && j + 1 < MAX_PARTS; j++) begin
			part_first[j] = part_first[j+1];
			part_last[j]  = part_last[j+1];
			part_taken[j] = part_taken[j+1];
			part_owner[j] = part_owner[j+1];
		end
		if (part_count > 0)
			part_count--;
	endfunction

	// First-fit allocate: take the front of the first free partition that fits.
	function automatic status_t place_block(req_t r, output rsp_t o);
		int unsigned len;
		o = '0;
		if (r.size == 0)
			return ST_ZERO;
		for (int i = 0; i < part_count && i < MAX_PARTS; i++) begin
			if (part_taken[i] || part_last[i] < part_first[i])
				continue;
			len = int'(part_last[i]) - int'(part_first[i]) + 1;
			if (len < r.size)
				continue;
			if (len != r.size) begin
				if (part_count >= MAX_PARTS)
					return ST_FULL;
				for (int j = part_count; j > i + 1; j--) begin
					part_first[j] = part_first[j-1];
					part_last[j]  = part_last[j-1];
					part_taken[j] = part_taken[j-1];
					part_owner[j] = part_owner[j-1];
				end
				part_first[i+1] = part_first[i] + r.size;
				part_last[i+1]  = part_last[i];
				part_taken[i+1] = 1'b0;
				part_owner[i+1] = '0;
				part_count++;
				part_last[i] = part_first[i] + r.size - 1'b1;
			end
			part_taken[i]  = 1'b1;
			part_owner[i]  = r.proc_id;
			o.block_begin  = part_first[i];
			o.block_end    = part_last[i];
			return ST_OK;
		end
		return ST_NOSPACE;
	endfunction

	// Release the first partition held by the owner and merge free neighbors.
	function automatic status_t release_block(req_t r, output rsp_t o);
		o = '0;
		for (int i = 0; i < part_count && i < MAX_PARTS; i++) begin
			if (!part_taken[i] || part_owner[i] != r.proc_id)
				continue;
			o.block_begin = part_first[i];
			o.block_end   = part_last[i];
			part_taken[i] = 1'b0;
			part_owner[i] = '0;
			if (i + 1 < part_count && i + 1 < MAX_PARTS && !part_taken[i+1]) begin
				part_last[i] = part_last[i+1];
				drop_entry(i + 1);
			end
			if (i > 0 && !part_taken[i-1]) begin
				part_last[i-1] = part_last[i];
				drop_entry(i);
			end
			return ST_OK;
		end
		return ST_NOOWNER;
	endfunction

	function automatic rsp_t predict_result(req_t r);
		rsp_t    o;
		status_t st;
		if (r.func == FUNC_ALLOC)
			st = place_block(r, o);
		else
			st = release_block(r, o);
		if (st != ST_OK)
			o = '0;
		o.status = st;
		return o;
	endfunction

	// Results first, then register writes, then newly accepted requests.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		if (!arst_n) begin
			sys_last = RESERVED_END_RST;
			mem_last = MEMORY_END_RST;
			reload_table();
			owed_q.delete();
			mismatch_count <= 0;
			result_count   <= 0;
			owed_count     <= 0;
		end else begin
			if (done) begin
				result_count <= result_count + 1;
				if (owed_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result with nothing owed: status %0d %0d..%0d",
							$time, rsp.status, rsp.block_begin, rsp.block_end);
					mismatch_count <= mismatch_count + 1;
				end else begin
					exp_r = owed_q.pop_front();
					if (rsp.status != exp_r.status || rsp.block_begin != exp_r.block_begin
							|| rsp.block_end != exp_r.block_end) begin
						if (mismatch_count < 10)
							$display("%0t: expected status %0d %0d..%0d, got status %0d %0d..%0d",
								$time, exp_r.status, exp_r.block_begin, exp_r.block_end,
								rsp.status, rsp.block_begin, rsp.block_end);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_RESERVED_END)
					sys_last = cfg_data;
				else
					mem_last = cfg_data;
				reload_table();
			end
			if (start && !busy)
				owed_q.insert(owed_q.size(), predict_result(req));
			owed_count <= owed_q.size();
		end
	end

endmodule

>>> tb/tb_first_fit_partition_allocator_top.sv
`timescale 1ns / 1ps

module tb_first_fit_partition_allocator_top;
	import ffpa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 50;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	req_t                 req;
	logic                 busy;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [0:0]           cfg_index;
	logic [ADDR_BITS-1:0] cfg_data;
	int                   mismatch_count;
	int                   owed_count;
	int                   result_count;
	int                   cycle_count = 0;
	int                   sent_count;
	bit                   no_gaps;

	first_fit_partition_allocator_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ffpa_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .owed_count(owed_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// One register transfer; the channel is checked for ready between edges.
	task automatic write_reg(logic [0:0] idx, logic [ADDR_BITS-1:0] value);
		bit taken;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	// Let every owed result arrive and the block go quiet, then set both bounds.
	task automatic set_bounds(logic [ADDR_BITS-1:0] sys_last, logic [ADDR_BITS-1:0] mem_last);
		wait (owed_count == 0);
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_RESERVED_END, sys_last);
		write_reg(REG_MEMORY_END, mem_last);
	endtask

	// One request transfer, after an optional random gap with start low.
	task automatic send(logic func, logic [7:0] id, logic [ADDR_BITS-1:0] size);
		bit taken;
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		req.func     <= func;
		req.proc_id  <= id;
		req.size     <= size;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sent_count++;
	endtask

	// Mostly owner-pool traffic that fills and drains the table, some noise.
	task automatic random_phase(int count, int span);
		int pick;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send(FUNC_ALLOC, 8'($urandom_range(1, 12)),
					10'($urandom_range(1, span > 1 ? span : 1)));
			else if (pick < 70)
				send(FUNC_FREE, 8'($urandom_range(0, 12)), 10'($urandom_range(0, 1023)));
			else
				send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					10'($urandom_range(0, 1023)));
		end
		start <= 1'b0;
	endtask

	initial begin
		sent_count  = 0;
		no_gaps     = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks on the reset layout of 0..39 system and 40..639 free.
		send(FUNC_ALLOC, 8'd1, 10'd0);
		send(FUNC_ALLOC, 8'd1, 10'd1023);
		send(FUNC_ALLOC, 8'd255, 10'd600);
		send(FUNC_FREE, 8'd7, 10'd5);
		send(FUNC_FREE, 8'd255, 10'd0);
		send(FUNC_FREE, 8'd0, 10'd0);
		send(FUNC_ALLOC, 8'd0, 10'd1);
		for (int k = 2; k < 16; k++)
			send(FUNC_ALLOC, 8'(k), 10'd1);
		send(FUNC_ALLOC, 8'd200, 10'd2);
		send(FUNC_ALLOC, 8'd128, 10'd625);
		send(FUNC_FREE, 8'd8, 10'd0);
		start <= 1'b0;

		// Random traffic under several bound settings, extremes included.
		random_phase(200, 80);
		set_bounds(10'd0, 10'd1023);
		random_phase(200, 150);
		set_bounds(10'd1022, 10'd1023);
		random_phase(140, 2);
		set_bounds(10'd500, 10'd20);
		random_phase(100, 20);
		set_bounds(10'd0, 10'd1);
		random_phase(140, 2);
		set_bounds(10'd100, 10'd300);
		random_phase(200, 30);

		wait (owed_count == 0);
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d requests and checked %0d results over six bound settings,",
			sent_count, result_count);
		$display("including zero size, exact fit, full table, owner zero and inverted bounds.");
		if (mismatch_count == 0 && owed_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
